// ===== src/krpc_pkg.sv =====
// ----------------------------------------------------------------------------
// krpc_pkg
// Shared types and constants for the key record and playback controller.
// ----------------------------------------------------------------------------
package krpc_pkg;

   localparam int STORE_DEPTH = 8192;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int IDX_W       = $clog2(STORE_DEPTH + 1);
   localparam int REC_W       = (IDX_W > 8) ? IDX_W : 8;
   localparam int CMP_W       = (IDX_W > 13) ? IDX_W : 13;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_HALF_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_REPEATS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PLAY_TICKS   = 2'd2;

   localparam logic [7:0]  BLINK_HALF_TICKS_RST = 8'd50;
   localparam logic [2:0]  BLINK_REPEATS_RST    = 3'd3;
   localparam logic [12:0] MIN_PLAY_TICKS_RST   = 13'd100;

   typedef struct packed {
      logic       record_button;
      logic       play_button;
      logic [7:0] live_keys;
   } req_type;

   typedef struct packed {
      logic       record_light;
      logic       play_light;
      logic       recorder_busy;
      logic       player_busy;
      logic [7:0] played_keys;
      logic       played_valid;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  blink_half_ticks;
      logic [2:0]  blink_repeats;
      logic [12:0] min_play_ticks;
   } cfg_type;

   typedef struct packed {
      logic              flag;
      logic              busy_nxt;
      logic              light_nxt;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [IDX_W-1:0]  length_nxt;
   } rec_status_type;

   typedef struct packed {
      logic              flag;
      logic              busy_nxt;
      logic              light_nxt;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } play_status_type;

endpackage

// ===== src/krpc_store.sv =====
// ----------------------------------------------------------------------------
// krpc_store
// Key byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module krpc_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [krpc_pkg::ADDR_W-1:0] wr_addr,
   input  logic [7:0]                  wr_data,
   input  logic                        rd_en,
   input  logic [krpc_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                  rd_data
);
   import krpc_pkg::*;

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/krpc_recorder.sv =====
// ----------------------------------------------------------------------------
// krpc_recorder
// Recorder state machine: arm on press and release, blink, then record.
// ----------------------------------------------------------------------------
module krpc_recorder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     record_button,
   input  logic                     player_flag,
   input  krpc_pkg::cfg_type        cfg,
   output krpc_pkg::rec_status_type status
);
   import krpc_pkg::*;

   typedef enum logic [5:0] {
      R_IDLE      = 6'b000001,
      R_HELD      = 6'b000010,
      R_BLINK_ON  = 6'b000100,
      R_BLINK_OFF = 6'b001000,
      R_RECORD    = 6'b010000,
      R_STOP      = 6'b100000
   } rec_mode_type;

   rec_mode_type     mode_ff, mode_in;
   logic [REC_W-1:0] idx_ff, idx_in;
   logic [2:0]       blink_ff, blink_in;
   logic [IDX_W-1:0] len_ff, len_in;

   always_comb begin
      mode_in  = mode_ff;
      idx_in   = idx_ff;
      blink_in = blink_ff;
      len_in   = len_ff;
      unique case (mode_ff)
         R_IDLE: begin
            if (record_button && !player_flag) mode_in = R_HELD;
         end
         R_HELD: begin
            if (!record_button) begin
               mode_in  = R_BLINK_ON;
               idx_in   = '0;
               blink_in = '0;
            end
         end
         R_BLINK_ON: begin
            if (blink_ff == cfg.blink_repeats) begin
               mode_in = R_RECORD;
               idx_in  = '0;
            end else if (idx_ff < REC_W'(cfg.blink_half_ticks)) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               mode_in = R_BLINK_OFF;
               idx_in  = '0;
            end
         end
         R_BLINK_OFF: begin
            if (idx_ff < REC_W'(cfg.blink_half_ticks)) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               mode_in  = R_BLINK_ON;
               idx_in   = '0;
               blink_in = blink_ff + 1'b1;
            end
         end
         R_RECORD: begin
            if (idx_ff < REC_W'(STORE_DEPTH) && !record_button) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               mode_in = record_button ? R_STOP : R_IDLE;
               len_in  = idx_ff[IDX_W-1:0];
               idx_in  = '0;
            end
         end
         R_STOP: begin
            if (!record_button) mode_in = R_IDLE;
         end
         default: begin
            mode_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= R_IDLE;
         idx_ff   <= '0;
         blink_ff <= '0;
         len_ff   <= IDX_W'(1);
      end else if (advance) begin
         mode_ff  <= mode_in;
         idx_ff   <= idx_in;
         blink_ff <= blink_in;
         len_ff   <= len_in;
      end
   end

   always_comb begin
      status.flag       = (mode_ff != R_IDLE);
      status.busy_nxt   = (mode_in != R_IDLE);
      status.light_nxt  = (mode_in == R_BLINK_ON) || (mode_in == R_RECORD);
      status.wr_en      = advance && (mode_in == R_RECORD) && (idx_in < REC_W'(STORE_DEPTH));
      status.wr_addr    = idx_in[ADDR_W-1:0];
      status.length_nxt = len_in;
   end

endmodule

// ===== src/krpc_player.sv =====
// ----------------------------------------------------------------------------
// krpc_player
// Player state machine: arm on press and release, then read back the store.
// ----------------------------------------------------------------------------
module krpc_player (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        play_button,
   input  logic                        recorder_flag,
   input  logic [krpc_pkg::IDX_W-1:0]  recorded_length,
   input  krpc_pkg::cfg_type           cfg,
   output krpc_pkg::play_status_type   status
);
   import krpc_pkg::*;

   typedef enum logic [3:0] {
      P_IDLE = 4'b0001,
      P_HELD = 4'b0010,
      P_PLAY = 4'b0100,
      P_STOP = 4'b1000
   } play_mode_type;

   play_mode_type    mode_ff, mode_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_comb begin
      mode_in = mode_ff;
      idx_in  = idx_ff;
      unique case (mode_ff)
         P_IDLE: begin
            if (play_button && !recorder_flag) mode_in = P_HELD;
         end
         P_HELD: begin
            if (!play_button) begin
               mode_in = P_PLAY;
               idx_in  = '0;
            end
         end
         P_PLAY: begin
            if (play_button && (CMP_W'(idx_ff) > CMP_W'(cfg.min_play_ticks))) begin
               mode_in = P_STOP;
               idx_in  = '0;
            end else if (idx_ff < recorded_length) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               mode_in = P_IDLE;
               idx_in  = '0;
            end
         end
         default: begin
            if (!play_button) mode_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= P_IDLE;
         idx_ff  <= '0;
      end else if (advance) begin
         mode_ff <= mode_in;
         idx_ff  <= idx_in;
      end
   end

   always_comb begin
      status.flag      = (mode_ff != P_IDLE);
      status.busy_nxt  = (mode_in != P_IDLE);
      status.light_nxt = (mode_in == P_PLAY);
      status.rd_en     = (mode_in == P_PLAY) && (idx_in < IDX_W'(STORE_DEPTH));
      status.rd_addr   = idx_in[ADDR_W-1:0];
   end

endmodule

// ===== src/key_record_playback_controller.sv =====
// ----------------------------------------------------------------------------
// key_record_playback_controller
// Pipeline: an accepted transaction passes the state update and store access
// stage, then read data capture, which offers the result.
// Throughput: one transaction per cycle while the response side is not stalled.
// Reset: synchronous; machines idle, config registers at defaults, store unwritten.
// Record and playback machines sharing one key byte store.
// ----------------------------------------------------------------------------
module key_record_playback_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  krpc_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output krpc_pkg::rsp_type               rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [krpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [krpc_pkg::CSR_DATA_W-1:0] csr_data
);
   import krpc_pkg::*;

   cfg_type         cfg_ff;
   rec_status_type  rec_st;
   play_status_type play_st;
   logic            accept;
   logic            s1_move;
   logic            s1_valid_ff;
   rsp_type         s1_rsp_ff;
   logic            s1_fwd_ff;
   logic            out_valid_ff;
   rsp_type         out_ff;
   logic [7:0]      rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_half_ticks <= BLINK_HALF_TICKS_RST;
         cfg_ff.blink_repeats    <= BLINK_REPEATS_RST;
         cfg_ff.min_play_ticks   <= MIN_PLAY_TICKS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BLINK_HALF_TICKS: cfg_ff.blink_half_ticks <= csr_data[7:0];
            CSR_BLINK_REPEATS:    cfg_ff.blink_repeats    <= csr_data[2:0];
            CSR_MIN_PLAY_TICKS:   cfg_ff.min_play_ticks   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign s1_move   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   krpc_recorder u_recorder (
      .clock         (clock),
      .reset         (reset),
      .advance       (accept),
      .record_button (req_payload.record_button),
      .player_flag   (play_st.flag),
      .cfg           (cfg_ff),
      .status        (rec_st)
   );

   krpc_player u_player (
      .clock           (clock),
      .reset           (reset),
      .advance         (accept),
      .play_button     (req_payload.play_button),
      .recorder_flag   (rec_st.flag),
      .recorded_length (rec_st.length_nxt),
      .cfg             (cfg_ff),
      .status          (play_st)
   );

   krpc_store u_store (
      .clock   (clock),
      .wr_en   (rec_st.wr_en),
      .wr_addr (rec_st.wr_addr),
      .wr_data (req_payload.live_keys),
      .rd_en   (accept && play_st.rd_en),
      .rd_addr (play_st.rd_addr),
      .rd_data (rd_data)
   );

   // stage-one valid; the next block flags a same-tick write and read of one entry
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rsp_ff.record_light  <= rec_st.light_nxt;
         s1_rsp_ff.play_light    <= play_st.light_nxt;
         s1_rsp_ff.recorder_busy <= rec_st.busy_nxt;
         s1_rsp_ff.player_busy   <= play_st.busy_nxt;
         s1_rsp_ff.played_keys   <= req_payload.live_keys;
         s1_rsp_ff.played_valid  <= play_st.rd_en;
         s1_fwd_ff <= rec_st.wr_en && play_st.rd_en && (rec_st.wr_addr == play_st.rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_ff.record_light  <= s1_rsp_ff.record_light;
         out_ff.play_light    <= s1_rsp_ff.play_light;
         out_ff.recorder_busy <= s1_rsp_ff.recorder_busy;
         out_ff.player_busy   <= s1_rsp_ff.player_busy;
         out_ff.played_valid  <= s1_rsp_ff.played_valid;
         priority if (!s1_rsp_ff.played_valid) begin
            out_ff.played_keys <= 8'd0;
         end else if (s1_fwd_ff) begin
            out_ff.played_keys <= s1_rsp_ff.played_keys;
         end else begin
            out_ff.played_keys <= rd_data;
         end
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule
